// ----- rtl/core/tts_pkg.sv -----
package tts_pkg;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs;
        logic [5:0]         idx;
        logic               is_last;
    } t_row;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [5:0]         row_index;
        logic               singular;
        logic               last;
    } t_res;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)       r = Q_MAX;
        else if (v < -65'sd2147483648) r = Q_MIN;
        else                           r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Quotient for a zero divisor: saturates by the sign of the dividend, zero for a zero dividend.
    function automatic logic signed [31:0] zero_div(input logic signed [31:0] n);
        logic signed [31:0] r;
        if (n > 32'sd0)      r = Q_MAX;
        else if (n < 32'sd0) r = Q_MIN;
        else                 r = 32'sd0;
        return r;
    endfunction

endpackage

// ----- rtl/core/tts_fifo.sv -----
module tts_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ----- rtl/core/tts_front.sv -----
module tts_front #(
    parameter int MAX_ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_sub_diag,
    input  logic signed [31:0]  i_main_diag,
    input  logic signed [31:0]  i_super_diag,
    input  logic signed [31:0]  i_rhs,
    input  logic                i_last_row,
    input  logic                i_pop,
    output tts_pkg::t_row       o_row,
    output logic                o_empty
);
    logic [5:0]    r_cnt;
    logic          accept;
    tts_pkg::t_row row;
    logic [$bits(tts_pkg::t_row)-1:0] q_out;

    assign accept = push && !full;

    // A system that reaches the row limit is closed there.
    always_comb begin
        row.sub_diag   = i_sub_diag;
        row.main_diag  = i_main_diag;
        row.super_diag = i_super_diag;
        row.rhs        = i_rhs;
        row.idx        = r_cnt;
        row.is_last    = i_last_row || (r_cnt == 6'(MAX_ROWS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (accept) begin
            r_cnt <= row.is_last ? 6'd0 : r_cnt + 6'd1;
        end
    end

    tts_fifo #(.W($bits(tts_pkg::t_row))) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (row),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );

    assign o_row = tts_pkg::t_row'(q_out);
endmodule

// ----- rtl/core/tts_engine.sv -----
module tts_engine #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tts_pkg::t_row i_row,
    input  logic          i_valid,
    output logic          o_pop,
    output tts_pkg::t_res o_res,
    output logic          o_push,
    input  logic          i_full
);
    localparam int W  = 32 + FRAC_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int AW = $clog2(MAX_ROWS);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MUL  = 11'b00000000010,
        S_PIV  = 11'b00000000100,
        S_PREP = 11'b00000001000,
        S_DIV  = 11'b00000010000,
        S_FIN  = 11'b00000100000,
        S_WR   = 11'b00001000000,
        S_EMIT = 11'b00010000000,
        S_BRD  = 11'b00100000000,
        S_BMUL = 11'b01000000000,
        S_BSUB = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    tts_pkg::t_row      r_row;
    logic signed [31:0] r_prev_c, r_prev_d;
    logic signed [63:0] r_p1, r_p2;
    logic signed [31:0] r_piv, r_num;
    logic [31:0]        r_den;
    logic [W-1:0]       r_sh_c, r_sh_d;
    logic [31:0]        r_rem_c, r_rem_d;
    logic               r_neg_c, r_neg_d;
    logic [CW-1:0]      r_bits;
    logic signed [31:0] r_cq, r_dq;
    logic signed [31:0] r_x;
    logic [5:0]         r_k;
    logic               r_zero;
    logic signed [31:0] r_rd_c, r_rd_d;
    logic signed [63:0] r_bp;

    logic signed [31:0] mem_c [MAX_ROWS];
    logic signed [31:0] mem_d [MAX_ROWS];

    logic [32:0] tr_c, tr_d;
    logic        qb_c, qb_d;

    function automatic logic signed [31:0] fin_q(input logic [W-1:0] q, input logic neg);
        logic signed [31:0] r;
        if (q[W-1:31] != '0) r = neg ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
        else                 r = neg ? 32'(-q[31:0]) : 32'(q[31:0]);
        return r;
    endfunction

    // Restoring division step on both quotients against the shared pivot.
    assign tr_c = {r_rem_c, r_sh_c[W-1]} - {1'b0, r_den};
    assign tr_d = {r_rem_d, r_sh_d[W-1]} - {1'b0, r_den};
    assign qb_c = !tr_c[32];
    assign qb_d = !tr_d[32];

    assign o_pop  = (r_state == S_IDLE) && i_valid;
    assign o_push = (r_state == S_EMIT) && !i_full;

    always_comb begin
        o_res.solution  = r_x;
        o_res.row_index = r_k;
        o_res.singular  = r_zero;
        o_res.last      = (r_k == 6'd0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL;
            S_MUL:  n_state = S_PIV;
            S_PIV:  n_state = S_PREP;
            S_PREP: n_state = (r_piv == 32'sd0) ? S_WR : S_DIV;
            S_DIV:  if (r_bits == CW'(1)) n_state = S_FIN;
            S_FIN:  n_state = S_WR;
            S_WR:   n_state = r_row.is_last ? S_EMIT : S_IDLE;
            S_EMIT: if (!i_full) n_state = (r_k == 6'd0) ? S_IDLE : S_BRD;
            S_BRD:  n_state = S_BMUL;
            S_BMUL: n_state = S_BSUB;
            S_BSUB: n_state = S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zero  <= 1'b0;
            r_k     <= 6'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_PREP: if (r_piv == 32'sd0) r_zero <= 1'b1;
                S_WR:   if (r_row.is_last) r_k <= r_row.idx;
                S_EMIT: begin
                    if (!i_full) begin
                        if (r_k == 6'd0) r_zero <= 1'b0;
                        else             r_k    <= r_k - 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_valid) r_row <= i_row;
            S_MUL: begin
                // Row 0 has no previous row to eliminate against.
                r_p1 <= (r_row.idx == 6'd0) ? 64'sd0 : r_row.sub_diag * r_prev_c;
                r_p2 <= (r_row.idx == 6'd0) ? 64'sd0 : r_row.sub_diag * r_prev_d;
            end
            S_PIV: begin
                r_piv <= tts_pkg::sat32(65'(r_row.main_diag) - 65'(r_p1 >>> FRAC_BITS));
                r_num <= tts_pkg::sat32(65'(r_row.rhs) - 65'(r_p2 >>> FRAC_BITS));
            end
            S_PREP: begin
                r_cq    <= tts_pkg::zero_div(r_row.super_diag);
                r_dq    <= tts_pkg::zero_div(r_num);
                r_den   <= tts_pkg::mag32(r_piv);
                r_sh_c  <= {tts_pkg::mag32(r_row.super_diag), FRAC_BITS'(0)};
                r_sh_d  <= {tts_pkg::mag32(r_num), FRAC_BITS'(0)};
                r_neg_c <= r_row.super_diag[31] ^ r_piv[31];
                r_neg_d <= r_num[31] ^ r_piv[31];
                r_rem_c <= 32'd0;
                r_rem_d <= 32'd0;
                r_bits  <= CW'(W);
            end
            S_DIV: begin
                r_rem_c <= qb_c ? tr_c[31:0] : {r_rem_c[30:0], r_sh_c[W-1]};
                r_rem_d <= qb_d ? tr_d[31:0] : {r_rem_d[30:0], r_sh_d[W-1]};
                r_sh_c  <= {r_sh_c[W-2:0], qb_c};
                r_sh_d  <= {r_sh_d[W-2:0], qb_d};
                r_bits  <= r_bits - CW'(1);
            end
            S_FIN: begin
                r_cq <= fin_q(r_sh_c, r_neg_c);
                r_dq <= fin_q(r_sh_d, r_neg_d);
            end
            S_WR: begin
                r_prev_c <= r_cq;
                r_prev_d <= r_dq;
                r_x      <= r_dq;
            end
            S_BRD: begin
                r_rd_c <= mem_c[r_k[AW-1:0]];
                r_rd_d <= mem_d[r_k[AW-1:0]];
            end
            S_BMUL: r_bp <= r_rd_c * r_x;
            S_BSUB: r_x  <= tts_pkg::sat32(65'(r_rd_d) - 65'(r_bp >>> FRAC_BITS));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem_c[r_row.idx[AW-1:0]] <= r_row.is_last ? 32'sd0 : r_cq;
            mem_d[r_row.idx[AW-1:0]] <= r_dq;
        end
    end
endmodule

// ----- rtl/core/tridiagonal_thomas_solver.sv -----
// Tridiagonal solver, Thomas algorithm, signed fixed point with FRAC_BITS
// fraction bits. Rows enter on a queue-style port (push/full); the row
// flagged last_row, or the row with index MAX_ROWS-1, closes the system.
// Results leave on a queue-style port (empty/pop), one beat per unknown,
// from the last row down to row 0, which carries o_last. o_singular flags
// a zero pivot seen anywhere in that system.
// The elimination engine finishes one row before it takes the next; the
// bit-serial divider dominates, working both quotients of a row at once,
// one quotient bit per cycle over 32+FRAC_BITS steps. Back substitution
// computes each beat after the first from a registered store read, a
// multiply and a subtract. A two-entry row queue decouples
// the input from the engine and a two-entry result queue decouples the
// output, so rows can be pushed while results wait.
// A stalled receiver holds the engine at the next result; nothing is lost.
// Synchronous reset empties both queues and starts a fresh system; the
// row stores need no clearing since only written entries are read.
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_sub_diag,
    input  logic signed [31:0] i_main_diag,
    input  logic signed [31:0] i_super_diag,
    input  logic signed [31:0] i_rhs,
    input  logic               i_last_row,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_solution,
    output logic [5:0]         o_row_index,
    output logic               o_singular,
    output logic               o_last
);
    tts_pkg::t_row row;
    logic          row_empty, row_pop;
    tts_pkg::t_res res, res_out;
    logic          res_push, res_full;
    logic [$bits(tts_pkg::t_res)-1:0] res_q;

    tts_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sub_diag   (i_sub_diag),
        .i_main_diag  (i_main_diag),
        .i_super_diag (i_super_diag),
        .i_rhs        (i_rhs),
        .i_last_row   (i_last_row),
        .i_pop        (row_pop),
        .o_row        (row),
        .o_empty      (row_empty)
    );

    tts_engine #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row),
        .i_valid (!row_empty),
        .o_pop   (row_pop),
        .o_res   (res),
        .o_push  (res_push),
        .i_full  (res_full)
    );

    tts_fifo #(.W($bits(tts_pkg::t_res))) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out     = tts_pkg::t_res'(res_q);
    assign o_solution  = res_out.solution;
    assign o_row_index = res_out.row_index;
    assign o_singular  = res_out.singular;
    assign o_last      = res_out.last;
endmodule

// ----- rtl/core/tts_checker.sv -----
module tts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_solution,
    input logic [5:0]  o_row_index,
    input logic        o_singular,
    input logic        o_last
);
    // A waiting beat that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_solution) && $stable(o_row_index)
                              && $stable(o_singular) && $stable(o_last)))
        else $error("result beat changed while stalled");

    a_last_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_row_index == 6'd0))
        else $error("last flag on a row other than 0");

    a_row0_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_row_index == 6'd0) |-> o_last)
        else $error("row 0 result without last flag");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results pending after reset");
endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_solution  (o_solution),
    .o_row_index (o_row_index),
    .o_singular  (o_singular),
    .o_last      (o_last)
);
